@@ src/ctlr_pkg.sv @@
// ----------------------------------------------------------------------------
// ctlr_pkg
// Shared constants for the clipped target linear ramp smoother.
// ----------------------------------------------------------------------------
package ctlr_pkg;

    // Default width of one Q16.16 sample or target value.
    localparam int CTLR_DATA_WIDTH = 32;

    // Width of the ramp length register, which is also the divisor width.
    localparam int CTLR_LEN_W = 16;

    // Ramp length after reset.
    localparam logic [CTLR_LEN_W-1:0] CTLR_LEN_RESET = 16'd480;

    // Configuration register indexes.
    localparam int CTLR_CFG_IDX_W = 2;
    localparam logic [CTLR_CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = 2'd0;
    localparam logic [CTLR_CFG_IDX_W-1:0] CFG_UPPER_LIMIT  = 2'd1;
    localparam logic [CTLR_CFG_IDX_W-1:0] CFG_RAMP_SAMPLES = 2'd2;
    localparam logic [CTLR_CFG_IDX_W-1:0] CFG_BYPASS_MODE  = 2'd3;

    // Input action codes.
    localparam logic ACT_SET_TARGET = 1'b0;
    localparam logic ACT_SAMPLE     = 1'b1;

endpackage

@@ src/ctlr_div.sv @@
// ----------------------------------------------------------------------------
// ctlr_div
// Iterative restoring divider: unsigned dividend by the ramp length, one
// quotient bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
module ctlr_div
    import ctlr_pkg::*;
#(
    parameter int W = CTLR_DATA_WIDTH + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_dividend,
    input  logic [CTLR_LEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [W-1:0]          o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_count;
    logic [W-1:0]          r_quo;
    logic [CTLR_LEN_W-1:0] r_rem;
    logic [CTLR_LEN_W-1:0] r_dvs;

    logic [CTLR_LEN_W:0]   rem_shift;
    logic [CTLR_LEN_W:0]   rem_diff;
    logic                  fits;

    // Bring down the next dividend bit and try one subtraction.
    assign rem_shift = {r_rem, r_quo[W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign fits      = (rem_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CW'(W);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], fits};
            r_rem <= fits ? rem_diff[CTLR_LEN_W-1:0] : rem_shift[CTLR_LEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/clipped_target_linear_ramp.sv @@
// ----------------------------------------------------------------------------
// clipped_target_linear_ramp
// Linear ramp smoother for an audio control parameter in Q16.16.
// ----------------------------------------------------------------------------
// A set transfer (action 0) gives a new target, clipped to the lower and upper
// limits when both are nonzero. A target that differs from the stored one is
// stored, and when not in bypass with a nonzero ramp length the per-sample
// step (target minus ramp value) divided by the ramp length is computed,
// truncated toward zero; a step that would be zero while the distance is not
// becomes one LSB toward the target. A sample transfer (action 1) yields one
// output: the input sample in bypass, otherwise the ramp advanced by one step
// and held at the target, otherwise the target itself.
// Timing: the result of a sample transfer sits in an output register. The
// next item can be accepted in the cycle in which that result is taken;
// while the result waits, the input is stalled as well. A set transfer
// passes through ST_SET and, when a step is computed, through ST_DIV, where
// the restoring divider produces one quotient bit per cycle. The input is
// stalled while a set transfer is in progress. Configuration writes take
// effect at once and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module clipped_target_linear_ramp
    import ctlr_pkg::*;
#(
    parameter int DATA_WIDTH = CTLR_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    // Result channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_sample_out,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [CTLR_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data
);

    // The step and the difference need one bit more than a sample.
    localparam int W  = DATA_WIDTH + 1;
    localparam int SW = DATA_WIDTH + 2;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // Configuration registers.
    logic signed [DATA_WIDTH-1:0] r_lower;
    logic signed [DATA_WIDTH-1:0] r_upper;
    logic [CTLR_LEN_W-1:0]        r_ramp_len;
    logic                         r_bypass;

    // Smoother state.
    logic signed [DATA_WIDTH-1:0] r_target;
    logic signed [DATA_WIDTH-1:0] r_ramp;
    logic signed [W-1:0]          r_step;

    // Set transfer in progress.
    logic [1:0]                   r_state;
    logic signed [DATA_WIDTH-1:0] r_pend;
    logic                         r_neg;
    logic                         r_diff_nz;

    // Output register.
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_data;

    logic                         accept;
    logic                         clip_en;
    logic signed [DATA_WIDTH-1:0] clipped;
    logic signed [W-1:0]          diff;
    logic [W-1:0]                 diff_mag;
    logic                         div_start;
    logic                         div_done;
    logic [W-1:0]                 div_quo;
    logic signed [W-1:0]          n_step;

    logic                         step_pos;
    logic                         step_neg;
    logic signed [SW-1:0]         sum;
    logic signed [SW-1:0]         tgt_x;
    logic                         hit;
    logic signed [DATA_WIDTH-1:0] y;
    logic                         ramp_adv;

    // A new item is taken only when no set transfer is in progress and the
    // output register is free or being emptied in this cycle.
    assign o_stall = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    // Clipping applies only when both limits are nonzero; the lower bound wins.
    assign clip_en = (r_lower != '0) && (r_upper != '0);
    always_comb begin
        clipped = i_value;
        if (clip_en) begin
            if (i_value < r_lower) begin
                clipped = r_lower;
            end else if (i_value > r_upper) begin
                clipped = r_upper;
            end
        end
    end

    // Distance to travel and its magnitude for the unsigned divider.
    assign diff      = W'(r_pend) - W'(r_ramp);
    assign diff_mag  = diff[W-1] ? (~diff + 1'b1) : diff;
    assign div_start = (r_state == ST_SET) && (r_pend != r_target) &&
                       !r_bypass && (r_ramp_len != '0);

    ctlr_div #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff_mag),
        .i_divisor  (r_ramp_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Restore the sign and turn a truncated zero step into one LSB.
    always_comb begin
        if (div_quo == '0) begin
            if (!r_diff_nz) begin
                n_step = '0;
            end else if (r_neg) begin
                n_step = '1;
            end else begin
                n_step = W'(1);
            end
        end else if (r_neg) begin
            n_step = ~div_quo + 1'b1;
        end else begin
            n_step = div_quo;
        end
    end

    // Sample path: advance the ramp and stop at the target when the step
    // reaches or passes it, is zero, or points the wrong way.
    assign step_neg = r_step[W-1];
    assign step_pos = !step_neg && (r_step != '0);
    assign sum      = SW'(r_ramp) + SW'(r_step);
    assign tgt_x    = SW'(r_target);
    assign hit      = (!step_pos && !step_neg) ||
                      (step_pos && (sum >= tgt_x)) ||
                      (step_neg && (sum <= tgt_x));
    assign ramp_adv = !r_bypass && (r_ramp_len != '0) && (r_ramp != r_target);

    always_comb begin
        if (r_bypass) begin
            y = i_value;
        end else if (ramp_adv) begin
            y = hit ? r_target : sum[DATA_WIDTH-1:0];
        end else begin
            y = r_target;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower    <= '0;
            r_upper    <= '0;
            r_ramp_len <= CTLR_LEN_RESET;
            r_bypass   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER_LIMIT: begin
                    r_lower <= i_cfg_data;
                end
                CFG_UPPER_LIMIT: begin
                    r_upper <= i_cfg_data;
                end
                CFG_RAMP_SAMPLES: begin
                    r_ramp_len <= i_cfg_data[CTLR_LEN_W-1:0];
                end
                CFG_BYPASS_MODE: begin
                    r_bypass <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer and smoother state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= '0;
            r_ramp      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A sample transfer refills the output register in the same cycle
            // in which its previous result may be leaving.
            if (accept && (i_action == ACT_SAMPLE)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_action == ACT_SET_TARGET) begin
                            r_state <= ST_SET;
                        end else begin
                            if (ramp_adv) begin
                                r_ramp <= y;
                                if (hit) begin
                                    r_step <= '0;
                                end
                            end
                        end
                    end
                end
                ST_SET: begin
                    if (r_pend != r_target) begin
                        r_target <= r_pend;
                    end
                    r_state <= div_start ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_step  <= n_step;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_SET_TARGET)) begin
            r_pend <= clipped;
        end
        if (accept && (i_action == ACT_SAMPLE)) begin
            r_out_data <= y;
        end
        if (r_state == ST_SET) begin
            r_neg     <= diff[W-1];
            r_diff_nz <= (diff != '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the clipped target linear ramp smoother.
// ----------------------------------------------------------------------------
// A queue of pending transfers is filled by the stimulus process and fed to
// the block by a clocked driver. A clocked monitor predicts every accepted
// input transfer with a local copy of the smoother state and compares each
// output transfer against the oldest predicted sample. A short directed part
// covers the extremes, clipping, tiny steps, stale and zero steps and bypass.
// Random phases with random register settings follow. Both channels idle at
// random, and once the receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top
    import ctlr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = CTLR_DATA_WIDTH;
    localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
    // Cycles to let pass once nothing is expected, covering a set transfer
    // that runs the full divider.
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 165;

    typedef struct {
        logic                  action;
        logic signed [DW-1:0]  value;
    } t_ramp_item;

    // ------------------------------------------------------------------------
    // DUT signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic                        o_stall;
    logic                        i_action    = ACT_SET_TARGET;
    logic signed [DW-1:0]        i_value     = '0;
    logic                        o_valid;
    logic                        i_stall     = 1'b0;
    logic signed [DW-1:0]        o_sample_out;
    logic                        i_cfg_we    = 1'b0;
    logic [CTLR_CFG_IDX_W-1:0]   i_cfg_index = CFG_LOWER_LIMIT;
    logic [DW-1:0]               i_cfg_data  = '0;

    clipped_target_linear_ramp #(
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: the smoother registers and the configuration that the
    // testbench believes the block holds.
    // ------------------------------------------------------------------------
    logic signed [DW-1:0]  lo_lim     = '0;
    logic signed [DW-1:0]  hi_lim     = '0;
    logic [CTLR_LEN_W-1:0] ramp_len   = CTLR_LEN_RESET;
    logic                  bypass_on  = 1'b0;
    logic signed [DW-1:0]  tgt_q      = '0;
    logic signed [DW-1:0]  ramp_q     = '0;
    logic signed [DW:0]    step_q     = '0;

    t_ramp_item            pending_items[$];
    logic signed [DW-1:0]  expected_samples[$];

    // Shared between the processes below.
    int         gap_max     = 13;
    int         hold_ticket = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    int         tx_wait     = 0;
    int         rx_wait     = 0;
    int         fail_count  = 0;
    bit         drv_busy    = 1'b0;
    logic       in_xfer     = 1'b0;
    logic       out_xfer    = 1'b0;
    t_ramp_item cur_item;
    logic signed [DW-1:0] exp_sample;

    // ------------------------------------------------------------------------
    // Clock and the run limit.
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor. Arithmetic is carried out in 64 bits so that the sum of the
    // ramp value and the step cannot wrap before it is compared with the
    // target, and the division truncates toward zero.
    // ------------------------------------------------------------------------
    task automatic smooth_item(input logic act, input logic signed [DW-1:0] val);
        longint t;
        longint diff;
        longint s;
        longint n;
        t = longint'(val);
        if (act == ACT_SET_TARGET) begin
            // Clipping only applies when both limits are nonzero; the lower
            // bound wins even if the limits are reversed.
            if (lo_lim != 0 && hi_lim != 0) begin
                if (t < lo_lim) begin
                    t = longint'(lo_lim);
                end else if (t > hi_lim) begin
                    t = longint'(hi_lim);
                end
            end
            if (t != longint'(tgt_q)) begin
                tgt_q = t[DW-1:0];
                // In bypass or with a zero ramp length the old step is kept.
                if (!bypass_on && ramp_len != 0) begin
                    diff = longint'(tgt_q) - longint'(ramp_q);
                    s = diff / longint'({1'b0, ramp_len});
                    // A step that truncates to zero still moves one LSB.
                    if (s == 0 && diff != 0) begin
                        s = (diff > 0) ? 1 : -1;
                    end
                    step_q = s[DW:0];
                end
            end
        end else begin
            if (bypass_on) begin
                expected_samples.push_back(val);
            end else if (ramp_len != 0 && ramp_q != tgt_q) begin
                n = longint'(ramp_q) + longint'(step_q);
                // A zero step, a step pointing away, or one that reaches or
                // passes the target all land exactly on the target.
                if (step_q == 0 || (step_q > 0 && n >= longint'(tgt_q)) ||
                        (step_q < 0 && n <= longint'(tgt_q))) begin
                    n = longint'(tgt_q);
                    step_q = '0;
                end
                ramp_q = n[DW-1:0];
                expected_samples.push_back(ramp_q);
            end else begin
                expected_samples.push_back(tgt_q);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. The output side is checked before the input side is predicted,
    // since a result leaving at this edge always belongs to an earlier input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_xfer  <= i_rst_n && (i_valid === 1'b1) && (o_stall === 1'b0);
        out_xfer <= i_rst_n && (o_valid === 1'b1) && (i_stall === 1'b0);
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_samples.size() == 0) begin
                if (fail_count < 10) begin
                    $display("ERROR: output transfer 0x%08h with nothing expected",
                             o_sample_out);
                end
                fail_count++;
            end else begin
                exp_sample = expected_samples.pop_front();
                if (o_sample_out !== exp_sample) begin
                    if (fail_count < 10) begin
                        $display("ERROR: sample_out expected 0x%08h got 0x%08h",
                                 exp_sample, o_sample_out);
                    end
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_valid === 1'b1 && o_stall === 1'b0) begin
            smooth_item(i_action, i_value);
        end
    end

    // ------------------------------------------------------------------------
    // Input driver. A payload is held until it is taken, then a random gap
    // of idle cycles is drawn before the next pending transfer goes out.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(drv_busy && !in_xfer)) begin
            if (in_xfer) begin
                drv_busy = 1'b0;
                tx_wait = $urandom_range(0, gap_max);
            end
            if (tx_wait > 0) begin
                tx_wait--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                i_action <= cur_item.action;
                i_value  <= cur_item.value;
                i_valid  <= 1'b1;
                drv_busy = 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver. Each result waits a random number of cycles before it
    // is taken. A hold request from the stimulus blocks all output transfers
    // for a long stretch so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (out_xfer) begin
            rx_wait = $urandom_range(0, gap_max);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (rx_wait > 0);
            if (o_valid === 1'b1 && rx_wait > 0) begin
                rx_wait--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic act, input logic signed [DW-1:0] val);
        t_ramp_item it;
        it.action = act;
        it.value  = val;
        pending_items.push_back(it);
    endtask

    // Waits until every queued transfer has gone out and every predicted
    // sample has come back, then lets a possible set transfer finish.
    task automatic drain();
        while (pending_items.size() != 0 || drv_busy || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register. Only the low bits of the narrow registers matter,
    // so the callers put random values in the rest.
    task automatic write_reg(input logic [CTLR_CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOWER_LIMIT:  lo_lim    = data;
            CFG_UPPER_LIMIT:  hi_lim    = data;
            CFG_RAMP_SAMPLES: ramp_len  = data[CTLR_LEN_W-1:0];
            CFG_BYPASS_MODE:  bypass_on = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [DW-1:0] len_word(input logic [CTLR_LEN_W-1:0] len);
        logic [DW-1:0] w;
        w = $urandom;
        w[CTLR_LEN_W-1:0] = len;
        return w;
    endfunction

    function automatic logic [DW-1:0] mode_word(input logic b);
        logic [DW-1:0] w;
        w = $urandom;
        w[0] = b;
        return w;
    endfunction

    // Mix of full-range values, the extremes, values near zero and scaled
    // values so that ramps of every size are exercised.
    function automatic logic signed [DW-1:0] pick_value();
        logic signed [DW-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            3: v = $signed($urandom_range(0, 64)) - 32;
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(1, 24);
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int count;
        int run;
        int run_max;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] tmp;
        logic [CTLR_LEN_W-1:0] len;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // After reset: ramp length 480 and no limits. A tick first returns
        // the zero target; a target of 100 then gives a one-LSB step since
        // 100 / 480 truncates to zero, and so does a small move downward.
        push_item(ACT_SAMPLE, 32'sh1234_5678);
        push_item(ACT_SET_TARGET, '0);
        push_item(ACT_SET_TARGET, 100);
        repeat (3) push_item(ACT_SAMPLE, Q_MAX);
        push_item(ACT_SET_TARGET, -5);
        push_item(ACT_SAMPLE, Q_MIN);
        drain();

        // A target set in bypass leaves the old step in place; in bypass the
        // sample passes through at both extremes.
        write_reg(CFG_BYPASS_MODE, mode_word(1'b1));
        push_item(ACT_SET_TARGET, 50);
        push_item(ACT_SAMPLE, Q_MAX);
        push_item(ACT_SAMPLE, Q_MIN);
        drain();

        // Out of bypass the stale step points away from the target, so the
        // next tick lands on it.
        write_reg(CFG_BYPASS_MODE, mode_word(1'b0));
        push_item(ACT_SAMPLE, '0);
        drain();

        // Zero ramp length: the target is stored with no step, then a nonzero
        // length sees the ramp apart from the target with a zero step.
        write_reg(CFG_RAMP_SAMPLES, len_word('0));
        push_item(ACT_SET_TARGET, Q_MAX);
        push_item(ACT_SAMPLE, '0);
        drain();
        write_reg(CFG_RAMP_SAMPLES, len_word(CTLR_LEN_W'(3)));
        push_item(ACT_SAMPLE, '0);
        // Full-scale swing: the difference needs the extra bit beyond a sample.
        push_item(ACT_SET_TARGET, Q_MIN);
        repeat (4) push_item(ACT_SAMPLE, '0);
        drain();

        // Clipping against both limits, with the longest ramp.
        write_reg(CFG_LOWER_LIMIT, -32'sh0001_0000);
        write_reg(CFG_UPPER_LIMIT, 32'sh0001_0000);
        write_reg(CFG_RAMP_SAMPLES, len_word('1));
        push_item(ACT_SET_TARGET, Q_MAX);
        repeat (2) push_item(ACT_SAMPLE, '0);
        push_item(ACT_SET_TARGET, Q_MIN);
        push_item(ACT_SAMPLE, '0);
        drain();

        // Reversed limits: the lower bound is tested first.
        write_reg(CFG_LOWER_LIMIT, 100);
        write_reg(CFG_UPPER_LIMIT, -100);
        push_item(ACT_SET_TARGET, 50);
        push_item(ACT_SET_TARGET, 200);
        push_item(ACT_SAMPLE, '0);
        drain();

        // With one limit zero no clipping takes place.
        write_reg(CFG_LOWER_LIMIT, '0);
        push_item(ACT_SET_TARGET, 32'sh7FFF_0000);
        push_item(ACT_SAMPLE, '0);
        drain();

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: begin a = '0; b = '0; end
                1: begin a = '0; b = $urandom; end
                2: begin a = Q_MIN; b = Q_MAX; end
                3: begin
                    a = $urandom;
                    b = $urandom;
                    if (a > b) begin
                        tmp = a; a = b; b = tmp;
                    end
                end
                default: begin
                    a = $urandom;
                    b = $urandom;
                    if (a < b) begin
                        tmp = a; a = b; b = tmp;
                    end
                end
            endcase
            case ($urandom_range(0, 7))
                0: len = '0;
                1: len = CTLR_LEN_W'(1);
                2: len = '1;
                3: len = CTLR_LEN_W'($urandom);
                4: len = CTLR_LEN_W'($urandom_range(17, 2000));
                default: len = CTLR_LEN_W'($urandom_range(2, 16));
            endcase
            // The first phases pin the extreme settings.
            if (ph == 0) begin
                a = Q_MIN; b = Q_MAX; len = '1;
            end else if (ph == 1) begin
                len = CTLR_LEN_W'(1);
            end
            write_reg(CFG_LOWER_LIMIT, a);
            write_reg(CFG_UPPER_LIMIT, b);
            write_reg(CFG_RAMP_SAMPLES, len_word(len));
            write_reg(CFG_BYPASS_MODE, mode_word($urandom_range(0, 5) == 0));
            gap_max = (ph == 2 || ph == 6) ? 0 : 13;

            // Back up the output while the sender keeps offering transfers.
            if (ph == 4) begin
                hold_ticket++;
            end

            run_max = (len == 0 || len > 18) ? 20 : len + 2;
            count = 0;
            while (count < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) != 0) begin
                    // A new target followed by a run of ticks.
                    push_item(ACT_SET_TARGET, pick_value());
                    run = $urandom_range(1, run_max);
                    repeat (run) push_item(ACT_SAMPLE, $urandom);
                    count += run + 1;
                end else begin
                    push_item($urandom_range(0, 1) ? ACT_SAMPLE : ACT_SET_TARGET,
                              pick_value());
                    count++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
